### design/lc3_pkg.sv
`default_nettype none
package lc3_pkg;

  // item operation codes
  localparam logic [2:0] OP_WRITE_MEM = 3'd0;
  localparam logic [2:0] OP_READ_MEM  = 3'd1;
  localparam logic [2:0] OP_EXECUTE   = 3'd2;
  localparam logic [2:0] OP_READ_ST   = 3'd3;
  localparam logic [2:0] OP_SET_PC    = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALTED  = 3'd1;
  localparam logic [2:0] ST_BAD_OPC = 3'd2;
  localparam logic [2:0] ST_RTI     = 3'd3;
  localparam logic [2:0] ST_BAD_TRP = 3'd4;
  localparam logic [2:0] ST_UNSUPP  = 3'd5;

  // condition code encoding
  localparam logic [1:0] CC_POS  = 2'd0;
  localparam logic [1:0] CC_ZERO = 2'd1;
  localparam logic [1:0] CC_NEG  = 2'd2;

  // instruction opcodes
  localparam logic [3:0] OPC_BR   = 4'h0;
  localparam logic [3:0] OPC_ADD  = 4'h1;
  localparam logic [3:0] OPC_LD   = 4'h2;
  localparam logic [3:0] OPC_ST   = 4'h3;
  localparam logic [3:0] OPC_JSR  = 4'h4;
  localparam logic [3:0] OPC_AND  = 4'h5;
  localparam logic [3:0] OPC_LDR  = 4'h6;
  localparam logic [3:0] OPC_STR  = 4'h7;
  localparam logic [3:0] OPC_RTI  = 4'h8;
  localparam logic [3:0] OPC_NOT  = 4'h9;
  localparam logic [3:0] OPC_LDI  = 4'hA;
  localparam logic [3:0] OPC_STI  = 4'hB;
  localparam logic [3:0] OPC_JMP  = 4'hC;
  localparam logic [3:0] OPC_RES  = 4'hD;
  localparam logic [3:0] OPC_LEA  = 4'hE;
  localparam logic [3:0] OPC_TRAP = 4'hF;

  // trap vectors
  localparam logic [7:0] TV_GETC  = 8'h20;
  localparam logic [7:0] TV_OUT   = 8'h21;
  localparam logic [7:0] TV_PUTS  = 8'h22;
  localparam logic [7:0] TV_IN    = 8'h23;
  localparam logic [7:0] TV_PUTSP = 8'h24;
  localparam logic [7:0] TV_HALT  = 8'h25;

  // state item indexes
  localparam logic [15:0] SI_PC   = 16'd8;
  localparam logic [15:0] SI_IR   = 16'd9;
  localparam logic [15:0] SI_CC   = 16'd10;
  localparam logic [15:0] SI_HALT = 16'd11;

  localparam logic [15:0] PC_RESET = 16'h3000;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] address;
    logic [15:0] data;
    logic [7:0]  char_in;
  } lc3_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] read_data;
    logic [15:0] pc_now;
    logic        is_halted;
    logic        char_valid;
    logic [7:0]  char_out;
  } lc3_out_t;

  function automatic logic [1:0] cc_of(input logic [15:0] v);
    if (v == 16'd0) return CC_ZERO;
    else if (v[15]) return CC_NEG;
    else return CC_POS;
  endfunction

endpackage
`default_nettype wire

### design/lc3_if.sv
`default_nettype none
interface lc3_in_if import lc3_pkg::*; ();
  logic    valid;
  logic    ready;
  lc3_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface lc3_out_if import lc3_pkg::*; ();
  logic     valid;
  logic     ready;
  lc3_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### design/lc3_instruction_executor.sv
// channel  | dir | payload                                          | handshake
// in_      | in  | op, address, data, char_in                       | valid/ready
// out_     | out | status, read_data, pc_now, is_halted, char_*     | valid/ready
// out_valid is high in S_OUT, reached through S_DONE for writes, state reads, PC sets
// and a step while halted, through S_MEMRD, S_DONE for a memory read, and through
// S_FETCH, S_EXEC, S_DONE for an instruction (fetch, execute, result), with S_MEMRD
// added for LD/LDR, S_IND for STI and both for LDI, all set by the single port of the
// main memory; back to idle after the out_ beat. After reset a clearing pass writes
// zero to every word with in_ready low. in_ready stays low while a beat waits on out_.
`default_nettype none
module lc3_instruction_executor import lc3_pkg::*; #(
  parameter int MEM_WORDS = 65536
) (
  input  wire        clk,
  input  wire        rst_n,
  lc3_in_if.sink     in_ch,
  lc3_out_if.source  out_ch
);

  localparam int AW = $clog2(MEM_WORDS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_IND   = 3'd4;
  localparam logic [2:0] S_MEMRD = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic [AW:0] clr_cnt_r, clr_cnt_nxt;
  lc3_in_t     item_r, item_nxt;
  lc3_out_t    res_r, res_nxt;
  logic [15:0] regs_r [8];
  logic [15:0] regs_nxt [8];
  logic [15:0] pc_r, pc_nxt, ir_r, ir_nxt;
  logic [1:0]  cc_r, cc_nxt;
  logic        halt_r, halt_nxt;

  // single-port main memory
  logic [15:0] mem [MEM_WORDS];
  logic [15:0] mem_q;
  logic        mem_we;
  logic [AW-1:0] mem_a;
  logic [15:0] mem_d;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_a] <= mem_d;
    mem_q <= mem[mem_a];
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = (state_r == S_OUT);
  assign out_ch.payload = res_r;

  logic [15:0] ir_w, pc_inc, off9, sr1v, opb, alu;
  logic [3:0]  opc;
  logic [2:0]  dr, sr1;
  logic        take;

  always_comb begin
    ir_w   = mem_q;
    opc    = ir_w[15:12];
    dr     = ir_w[11:9];
    sr1    = ir_w[8:6];
    pc_inc = pc_r + 16'd1;
    off9   = {{7{ir_w[8]}}, ir_w[8:0]};
    sr1v   = regs_r[sr1];
    opb    = ir_w[5] ? {{11{ir_w[4]}}, ir_w[4:0]} : regs_r[ir_w[2:0]];
    alu    = (opc == OPC_ADD) ? sr1v + opb : sr1v & opb;
    take   = (ir_w[11] && cc_r == CC_NEG) || (ir_w[10] && cc_r == CC_ZERO) ||
             (ir_w[9] && cc_r == CC_POS);
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    item_nxt    = item_r;
    res_nxt     = res_r;
    regs_nxt    = regs_r;
    pc_nxt      = pc_r;
    ir_nxt      = ir_r;
    cc_nxt      = cc_r;
    halt_nxt    = halt_r;
    mem_we      = 1'b0;
    mem_a       = item_r.address[AW-1:0];
    mem_d       = item_r.data;
    case (state_r)
      // zero the memory one word a cycle
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_a       = clr_cnt_r[AW-1:0];
        mem_d       = 16'd0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == (AW+1)'(MEM_WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          item_nxt          = in_ch.payload;
          res_nxt           = '0;
          res_nxt.pc_now    = pc_r;
          res_nxt.is_halted = halt_r;
          state_nxt         = S_DONE;
          case (in_ch.payload.op)
            OP_WRITE_MEM: begin
              mem_we = 1'b1;
              mem_a  = in_ch.payload.address[AW-1:0];
              mem_d  = in_ch.payload.data;
            end
            OP_READ_MEM: begin
              mem_a     = in_ch.payload.address[AW-1:0];
              state_nxt = S_MEMRD;
            end
            OP_EXECUTE: begin
              if (halt_r) res_nxt.status = ST_HALTED;
              else begin
                mem_a     = pc_r[AW-1:0];
                state_nxt = S_FETCH;
              end
            end
            OP_READ_ST: begin
              if (in_ch.payload.address < 16'd8)
                res_nxt.read_data = regs_r[in_ch.payload.address[2:0]];
              else if (in_ch.payload.address == SI_PC) res_nxt.read_data = pc_r;
              else if (in_ch.payload.address == SI_IR) res_nxt.read_data = ir_r;
              else if (in_ch.payload.address == SI_CC)
                res_nxt.read_data = {14'd0, cc_r};
              else if (in_ch.payload.address == SI_HALT)
                res_nxt.read_data = {15'd0, halt_r};
            end
            OP_SET_PC: begin
              pc_nxt            = in_ch.payload.data;
              halt_nxt          = 1'b0;
              res_nxt.pc_now    = in_ch.payload.data;
              res_nxt.is_halted = 1'b0;
            end
            default: ;
          endcase
        end
      end
      // hold the fetch address so mem_q keeps the instruction word
      S_FETCH: begin
        mem_a     = pc_r[AW-1:0];
        state_nxt = S_EXEC;
      end
      // decode and execute the fetched word
      S_EXEC: begin
        ir_nxt    = ir_w;
        state_nxt = S_DONE;
        if (opc == OPC_RES) res_nxt.status = ST_BAD_OPC;
        else if (opc == OPC_RTI) res_nxt.status = ST_RTI;
        else begin
          pc_nxt = pc_inc;
          case (opc)
            OPC_ADD, OPC_AND: begin
              regs_nxt[dr] = alu;
              cc_nxt       = cc_of(alu);
            end
            OPC_NOT: begin
              regs_nxt[dr] = ~sr1v;
              cc_nxt       = cc_of(~sr1v);
            end
            OPC_BR: if (take) pc_nxt = pc_inc + off9;
            OPC_JMP: pc_nxt = sr1v;
            OPC_JSR: begin
              regs_nxt[7] = pc_inc;
              pc_nxt = ir_w[11] ? pc_inc + {{5{ir_w[10]}}, ir_w[10:0]} : sr1v;
            end
            OPC_LEA: begin
              regs_nxt[dr] = pc_inc + off9;
              cc_nxt       = cc_of(pc_inc + off9);
            end
            OPC_LD, OPC_LDI: begin
              mem_a     = AW'(pc_inc + off9);
              state_nxt = (opc == OPC_LDI) ? S_IND : S_MEMRD;
            end
            OPC_LDR: begin
              mem_a     = AW'(sr1v + {{10{ir_w[5]}}, ir_w[5:0]});
              state_nxt = S_MEMRD;
            end
            OPC_ST: begin
              mem_we = 1'b1;
              mem_a  = AW'(pc_inc + off9);
              mem_d  = regs_r[dr];
            end
            OPC_STR: begin
              mem_we = 1'b1;
              mem_a  = AW'(sr1v + {{10{ir_w[5]}}, ir_w[5:0]});
              mem_d  = regs_r[dr];
            end
            OPC_STI: begin
              mem_a     = AW'(pc_inc + off9);
              state_nxt = S_IND;
            end
            default: begin
              regs_nxt[7] = pc_inc;
              case (ir_w[7:0])
                TV_GETC, TV_IN: regs_nxt[0] = {8'd0, item_r.char_in};
                TV_OUT: begin
                  res_nxt.char_valid = 1'b1;
                  res_nxt.char_out   = regs_r[0][7:0];
                end
                TV_PUTS, TV_PUTSP: res_nxt.status = ST_UNSUPP;
                TV_HALT: halt_nxt = 1'b1;
                default: res_nxt.status = ST_BAD_TRP;
              endcase
            end
          endcase
        end
      end
      // pointer word for LDI / STI ready in mem_q
      S_IND: begin
        if (ir_r[15:12] == OPC_STI) begin
          mem_we    = 1'b1;
          mem_a     = mem_q[AW-1:0];
          mem_d     = regs_r[ir_r[11:9]];
          state_nxt = S_DONE;
        end else begin
          mem_a     = mem_q[AW-1:0];
          state_nxt = S_MEMRD;
        end
      end
      // memory read data ready
      S_MEMRD: begin
        state_nxt = S_DONE;
        if (item_r.op == OP_READ_MEM) res_nxt.read_data = mem_q;
        else begin
          regs_nxt[ir_r[11:9]] = mem_q;
          cc_nxt               = cc_of(mem_q);
        end
      end
      S_DONE: begin
        res_nxt.pc_now    = pc_r;
        res_nxt.is_halted = halt_r;
        state_nxt         = S_OUT;
      end
      default: if (out_ch.ready) state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      regs_r    <= '{default: 16'd0};
      pc_r      <= PC_RESET;
      ir_r      <= 16'd0;
      cc_r      <= CC_ZERO;
      halt_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      regs_r    <= regs_nxt;
      pc_r      <= pc_nxt;
      ir_r      <= ir_nxt;
      cc_r      <= cc_nxt;
      halt_r    <= halt_nxt;
    end
    item_r <= item_nxt;
    res_r  <= res_nxt;
  end

endmodule
`default_nettype wire

### design/lc3_checker.sv
`default_nettype none
module lc3_checker import lc3_pkg::*; (
  input wire      clk,
  input wire      rst_n,
  input wire      in_valid,
  input wire      in_ready,
  input wire      out_valid,
  input wire      out_ready,
  input wire lc3_out_t out_payload
);
  // result payload holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_payload)) else $error("payload moved");
  // no new beat taken while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("in and out open together");
  // input closes after a beat is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second beat taken");
  // a character is only reported with ok status
  a_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.char_valid |-> out_payload.status == ST_OK)
    else $error("char with error status");
  // status is never beyond the defined codes
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_payload.status <= ST_UNSUPP) else $error("bad status");
endmodule

bind lc3_instruction_executor lc3_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload)
);
`default_nettype wire
